FILE: rtl/gfinv_pkg.sv
// shared types and constants for the gf(2^m) inverse block
package gfinv_pkg;

    localparam int FIELD_DEGREE_DEF = 10;
    localparam int MODULUS_RESET_DEF = 1033;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic reduce;
        logic swap;
        logic finish;
        logic fail;
        logic sel_v0;
    } dp_cmd_t;

    typedef struct packed {
        logic r0_zero;
        logic r0_one;
        logic r1_zero;
        logic r1_one;
        logic div_done;
    } dp_status_t;

endpackage

FILE: rtl/gfinv_in_if.sv
// operand channel interface
interface gfinv_in_if import gfinv_pkg::*; #(
    parameter int FIELD_DEGREE = FIELD_DEGREE_DEF
);
    logic                    valid;
    logic                    ready;
    logic [FIELD_DEGREE-1:0] operand;

    modport source (output valid, output operand, input ready);
    modport sink (input valid, input operand, output ready);
endinterface

FILE: rtl/gfinv_out_if.sv
// result channel interface
interface gfinv_out_if import gfinv_pkg::*; #(
    parameter int FIELD_DEGREE = FIELD_DEGREE_DEF
);
    logic                    valid;
    logic                    ready;
    logic [FIELD_DEGREE-1:0] inverse;
    logic                    no_inverse;

    modport source (output valid, output inverse, output no_inverse, input ready);
    modport sink (input valid, input inverse, input no_inverse, output ready);
endinterface

FILE: rtl/gf2m_inverse_ext_euclid.sv
// gf(2^m) inverse by the extended euclidean algorithm, top level
// sequence: a load step, a check step, then one reduce step per nonzero quotient bit
//   and one swap step per euclid round; a finished result also waits while the output register is full
// throughput: one item at a time; the next operand is taken the cycle after a result
//   is registered, while that result waits in the output register
// reset: asynchronous active low; control goes idle, modulus returns to x^10+x^3+1
module gf2m_inverse_ext_euclid import gfinv_pkg::*; #(
    parameter int FIELD_DEGREE = FIELD_DEGREE_DEF,
    parameter logic [FIELD_DEGREE:0] MODULUS_RESET = (FIELD_DEGREE + 1)'(MODULUS_RESET_DEF)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [FIELD_DEGREE:0] cfg_wdata,
    gfinv_in_if.sink              operand_chan,
    gfinv_out_if.source           result_chan
);

    dp_cmd_t    cmd;
    dp_status_t status;

    gfinv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operand_chan.valid),
        .in_ready  (operand_chan.ready),
        .out_valid (result_chan.valid),
        .out_ready (result_chan.ready),
        .status    (status),
        .cmd       (cmd)
    );

    gfinv_dp #(
        .FIELD_DEGREE  (FIELD_DEGREE),
        .MODULUS_RESET (MODULUS_RESET)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .operand    (operand_chan.operand),
        .cmd        (cmd),
        .status     (status),
        .inverse    (result_chan.inverse),
        .no_inverse (result_chan.no_inverse)
    );

endmodule

FILE: rtl/gfinv_dp.sv
// euclid datapath: remainder pair, coefficient pair, modulus and result registers
module gfinv_dp import gfinv_pkg::*; #(
    parameter int FIELD_DEGREE = FIELD_DEGREE_DEF,
    parameter logic [FIELD_DEGREE:0] MODULUS_RESET = (FIELD_DEGREE + 1)'(MODULUS_RESET_DEF)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [FIELD_DEGREE:0]   cfg_wdata,
    input  logic [FIELD_DEGREE-1:0] operand,
    input  dp_cmd_t                 cmd,
    output dp_status_t              status,
    output logic [FIELD_DEGREE-1:0] inverse,
    output logic                    no_inverse
);

    localparam int PW = FIELD_DEGREE + 1;
    localparam int DW = $clog2(PW);

    logic [PW-1:0]           modulus_reg;
    logic [PW-1:0]           r0_reg;
    logic [PW-1:0]           r1_reg;
    logic [FIELD_DEGREE-1:0] v0_reg;
    logic [FIELD_DEGREE-1:0] v1_reg;
    logic [FIELD_DEGREE-1:0] inverse_reg;
    logic                    no_inv_reg;

    logic [DW-1:0]           d0;
    logic [DW-1:0]           d1;
    logic [DW-1:0]           sh;
    logic [PW-1:0]           r0_red;
    logic [FIELD_DEGREE-1:0] v0_red;

    // leading-one position, zero for the zero polynomial
    function automatic logic [DW-1:0] poly_deg(input logic [PW-1:0] p);
        logic [DW-1:0] d;
        d = '0;
        for (int i = 0; i < PW; i++)
        begin
            if (p[i])
                d = DW'(i);
        end
        return d;
    endfunction

    // one long-division step cancels the top bit of r0
    always_comb
    begin
        d0 = poly_deg(r0_reg);
        d1 = poly_deg(r1_reg);
        sh = d0 - d1;
        r0_red = r0_reg ^ (r1_reg << sh);
        v0_red = v0_reg ^ (v1_reg << sh);
        status.r0_zero  = (r0_reg == '0);
        status.r0_one   = (r0_reg == PW'(1));
        status.r1_zero  = (r1_reg == '0);
        status.r1_one   = (r1_reg == PW'(1));
        status.div_done = (r0_reg == '0) || (d0 < d1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r0_reg <= modulus_reg;
            r1_reg <= {1'b0, operand};
            v0_reg <= '0;
            v1_reg <= FIELD_DEGREE'(1);
        end
        else if (cmd.reduce)
        begin
            r0_reg <= r0_red;
            v0_reg <= v0_red;
        end
        else if (cmd.swap)
        begin
            r0_reg <= r1_reg;
            r1_reg <= r0_reg;
            v0_reg <= v1_reg;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_reg <= '0;
            no_inv_reg  <= 1'b0;
        end
        else if (cmd.finish)
        begin
            no_inv_reg <= cmd.fail;
            if (cmd.fail)
                inverse_reg <= '0;
            else if (cmd.sel_v0)
                inverse_reg <= v0_reg;
            else
                inverse_reg <= v1_reg;
        end
    end

    assign inverse    = inverse_reg;
    assign no_inverse = no_inv_reg;

`ifndef ASSERT_OFF
    // every reduction leaves the dividend smaller than before
    a_reduce_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.reduce |=> (r0_reg < $past(r0_reg)))
        else $error("reduction did not lower the remainder");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        no_inv_reg |-> (inverse_reg == '0))
        else $error("failed inversion carries a nonzero result");
`endif

endmodule

FILE: rtl/gfinv_ctrl.sv
// sequencer for the euclid rounds and the result handshake
module gfinv_ctrl import gfinv_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // operand of zero or one needs no round
                if (status.r1_zero || status.r1_one)
                begin
                    if (slot_free)
                    begin
                        cmd.finish = 1'b1;
                        cmd.fail   = status.r1_zero;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!status.div_done)
                begin
                    cmd.reduce = 1'b1;
                end
                else if (status.r0_zero || status.r0_one)
                begin
                    // remainder becomes the new divisor: zero fails, one ends
                    if (slot_free)
                    begin
                        cmd.swap   = 1'b1;
                        cmd.finish = 1'b1;
                        cmd.fail   = status.r0_zero;
                        cmd.sel_v0 = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.swap = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_run_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (!status.r1_zero && !status.r1_one))
        else $error("round running with a trivial divisor");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before its transaction");
`endif

endmodule

FILE: dv/gf2m_inverse_ext_euclid_tb.sv
// testbench for the gf(2^10) extended euclidean inverse block
`timescale 1ns / 100ps

module gf2m_inverse_ext_euclid_tb;
    import gfinv_pkg::*;

    localparam int FD = FIELD_DEGREE_DEF;
    localparam logic [FD:0] MODULUS_AT_RESET = (FD + 1)'(MODULUS_RESET_DEF);

    typedef struct packed {
        logic [FD-1:0] inverse;
        logic          no_inverse;
    } inv_result_t;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [FD:0]   cfg_wdata;

    gfinv_in_if  #(.FIELD_DEGREE(FD)) op_if ();
    gfinv_out_if #(.FIELD_DEGREE(FD)) res_if ();

    inv_result_t   expected_inverses[$];
    logic [FD:0]   modulus_model;
    bit            sender_gaps_on;
    bit            sink_stalls_on;
    int            stall_left;
    int            error_count;

    gf2m_inverse_ext_euclid #(
        .FIELD_DEGREE(FD)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .operand_chan (op_if),
        .result_chan  (res_if)
    );

    always #2 clk = ~clk;

    function automatic int poly_degree(logic [63:0] p);
        int d;
        d = -1;
        while (p != 64'd0)
        begin
            p = p >> 1;
            d++;
        end
        return d;
    endfunction

    function automatic logic [63:0] carryless_mul(logic [63:0] x, logic [63:0] y);
        logic [63:0] acc;
        int i;
        acc = '0;
        for (i = 0; i < 64; i++)
        begin
            if (y[i])
                acc ^= x << i;
        end
        return acc;
    endfunction

    // euclid rounds from (modulus, element) with bezout coefficients (0, 1)
    function automatic inv_result_t predict_inverse(logic [FD:0] modulus, logic [FD-1:0] elem);
        logic [63:0] r0, r1, v0, v1, quot, rem, vn;
        int          d0, d1, i;
        logic        fail;
        inv_result_t res;
        r0 = 64'(modulus);
        r1 = 64'(elem);
        v0 = 64'd0;
        v1 = 64'd1;
        fail = (r1 == 64'd0);
        while (!fail && r1 > 64'd1)
        begin
            d0 = poly_degree(r0);
            d1 = poly_degree(r1);
            quot = '0;
            rem = r0;
            // a divisor of higher degree gives quotient 0 and just swaps the pair
            for (i = d0 - d1; i >= 0; i--)
            begin
                if (rem[i + d1])
                begin
                    quot[i] = 1'b1;
                    rem ^= r1 << i;
                end
            end
            vn = v0 ^ carryless_mul(quot, v1);
            r0 = r1;
            r1 = rem;
            v0 = v1;
            v1 = vn;
            if (r1 == 64'd0)
                fail = 1'b1;
        end
        res.inverse = fail ? '0 : v1[FD-1:0];
        res.no_inverse = fail;
        return res;
    endfunction

    // mostly short pauses, now and then a long one
    function automatic int random_pause_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [FD-1:0] random_operand();
        case ($urandom_range(0, 9))
            0: return FD'($urandom_range(0, 3));
            1: return FD'(1) << $urandom_range(0, FD - 1);
            2: return {FD{1'b1}} ^ (FD'(1) << $urandom_range(0, FD - 1));
            default: return FD'($urandom_range(0, (1 << FD) - 1));
        endcase
    endfunction

    task automatic send_operand(input logic [FD-1:0] value);
        int gap;
        gap = 0;
        if (sender_gaps_on && $urandom_range(0, 1) == 0)
            gap = random_pause_len();
        if (gap > 0)
        begin
            op_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op_if.valid   <= 1'b1;
        op_if.operand <= value;
        do @(posedge clk); while (!op_if.ready);
        expected_inverses.push_back(predict_inverse(modulus_model, value));
    endtask

    task automatic drain_results();
        op_if.valid <= 1'b0;
        while (expected_inverses.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_modulus(input logic [FD:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        modulus_model = value;
    endtask

    task automatic send_random(input int count);
        int n;
        for (n = 0; n < count; n++)
            send_operand(random_operand());
    endtask

    // reset modulus x^10+x^3+1, zero and one operands, extremes of the field
    task automatic test_reset_modulus();
        send_operand('0);
        send_operand(FD'(1));
        send_operand(FD'(2));
        send_operand(FD'(3));
        send_operand({FD{1'b1}});
        send_operand(FD'(1) << (FD - 1));
        send_operand(FD'(10'h155));
        send_operand(FD'(10'h2aa));
    endtask

    // reducible moduli x^10+1 and x^10, so some remainders reach zero, and the all-ones modulus
    task automatic test_reducible_moduli();
        write_modulus((FD + 1)'(1) << FD | (FD + 1)'(1));
        send_operand(FD'(3));
        send_operand(FD'(2));
        send_operand({FD{1'b1}});
        write_modulus((FD + 1)'(1) << FD);
        send_operand(FD'(2));
        send_operand(FD'(1));
        write_modulus({(FD + 1){1'b1}});
        send_operand(FD'(3));
        send_operand({FD{1'b1}});
    endtask

    // moduli without the top bit, zero and one among them
    task automatic test_narrow_moduli();
        write_modulus('0);
        send_operand(FD'(5));
        send_operand(FD'(1));
        write_modulus((FD + 1)'(1));
        send_operand(FD'(6));
        write_modulus((FD + 1)'(11));
        send_operand(FD'(7));
        send_operand({FD{1'b1}});
        write_modulus((FD + 1)'({FD{1'b1}}));
        send_operand(FD'(1) << (FD - 1));
    endtask

    task automatic test_random_phases();
        write_modulus(MODULUS_AT_RESET);
        send_random(75);
        // hold off the sender until the block has drained
        drain_results();
        send_random(75);

        sender_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        send_random(60);
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;

        write_modulus((FD + 1)'($urandom_range(1 << FD, (1 << (FD + 1)) - 1)));
        send_random(100);
        write_modulus((FD + 1)'($urandom_range(0, (1 << (FD + 1)) - 1)));
        send_random(60);
        write_modulus({(FD + 1){1'b1}});
        send_random(50);
        write_modulus((FD + 1)'(1) << FD);
        send_random(40);

        sender_gaps_on = 1'b0;
        write_modulus((FD + 1)'($urandom_range(1 << FD, (1 << (FD + 1)) - 1)));
        send_random(100);
        sender_gaps_on = 1'b1;

        write_modulus(MODULUS_AT_RESET);
        send_random(40);
    endtask

    // result side: random stalls and comparison against the oldest expectation
    always @(posedge clk)
    begin
        inv_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_inverses.size() == 0)
            begin
                $error("result with no pending transaction: inverse %0d no_inverse %0b",
                       res_if.inverse, res_if.no_inverse);
                error_count++;
            end
            else
            begin
                want = expected_inverses.pop_front();
                if (res_if.inverse !== want.inverse)
                begin
                    $error("inverse: expected %0d, actual %0d", want.inverse, res_if.inverse);
                    error_count++;
                end
                if (res_if.no_inverse !== want.no_inverse)
                begin
                    $error("no_inverse: expected %0b, actual %0b",
                           want.no_inverse, res_if.no_inverse);
                    error_count++;
                end
            end
        end
        if (stall_left > 0)
        begin
            res_if.ready <= 1'b0;
            stall_left--;
        end
        else if (sink_stalls_on && $urandom_range(0, 4) == 0)
        begin
            res_if.ready <= 1'b0;
            stall_left = random_pause_len() - 1;
        end
        else
            res_if.ready <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        op_if.valid = 1'b0;
        op_if.operand = '0;
        res_if.ready = 1'b0;
        modulus_model = MODULUS_AT_RESET;
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        stall_left = 0;
        error_count = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_modulus();
        test_reducible_moduli();
        test_narrow_moduli();
        test_random_phases();

        drain_results();
        repeat (30) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
